FILE: rtl/rk4_pkg.sv
// ============================================================================
// RK4 step unit package
// Shared types, operation and operand codes, saturating arithmetic helpers
// and the microcode table of the RK4 step sequencer.
// ============================================================================
package rk4_pkg;

    localparam int FRAC_BITS_DEF = 40;
    localparam int CFG_IDX_W     = 8;
    localparam int PC_W          = 7;

    localparam logic [63:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] T52_MAX64 = 64'h0007_FFFF_FFFF_FFFF;
    localparam logic [63:0] T52_MIN64 = 64'hFFF8_0000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_STEP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ST_T  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ST_Y  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ST_V  = 8'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    typedef logic [3:0] op_t;
    localparam op_t OP_END   = 4'd0;
    localparam op_t OP_MOV   = 4'd1;
    localparam op_t OP_ADD   = 4'd2;
    localparam op_t OP_SUB   = 4'd3;
    localparam op_t OP_HALF  = 4'd4;
    localparam op_t OP_MUL   = 4'd5;
    localparam op_t OP_DIV   = 4'd6;
    localparam op_t OP_DIV6  = 4'd7;
    localparam op_t OP_SAT52 = 4'd8;
    localparam op_t OP_JZ    = 4'd9;

    typedef logic [3:0] addr_t;
    localparam addr_t A_T  = 4'd0;
    localparam addr_t A_Y  = 4'd1;
    localparam addr_t A_V  = 4'd2;
    localparam addr_t A_H  = 4'd3;
    localparam addr_t A_ST = 4'd4;
    localparam addr_t A_SY = 4'd5;
    localparam addr_t A_SV = 4'd6;
    localparam addr_t A_TH = 4'd7;
    localparam addr_t A_TF = 4'd8;
    localparam addr_t A_YK = 4'd9;
    localparam addr_t A_AK = 4'd10;
    localparam addr_t A_B  = 4'd11;
    localparam addr_t A_SA = 4'd12;
    localparam addr_t A_SB = 4'd13;
    localparam addr_t A_X1 = 4'd14;
    localparam addr_t A_X2 = 4'd15;

    localparam logic [PC_W-1:0] PC_RESTART = 7'd0;
    localparam logic [PC_W-1:0] PC_STEP    = 7'd4;
    localparam logic [PC_W-1:0] PC_LAST    = 7'd78;

    typedef struct packed {
        op_t             op;
        addr_t           dst;
        addr_t           sa;
        addr_t           sb;
        logic [PC_W-1:0] tgt;
    } ucode_t;

    function automatic ucode_t uw(op_t op, addr_t dst, addr_t sa, addr_t sb);
        ucode_t w;
        w.op  = op;
        w.dst = dst;
        w.sa  = sa;
        w.sb  = sb;
        w.tgt = PC_LAST;
        return w;
    endfunction

    // Acceleration -y/t + y/t^2 - y + y^3 into A_B, nine words.
    function automatic ucode_t accel_word(logic [3:0] k, addr_t ys, addr_t ts);
        ucode_t w;
        case (k)
            4'd0: w = uw(OP_MUL, A_X1, ts, ts);
            4'd1: w = uw(OP_JZ, A_X1, ts, A_X1);
            4'd2: w = uw(OP_DIV, A_X2, ys, A_X1);
            4'd3: w = uw(OP_DIV, A_X1, ys, ts);
            4'd4: w = uw(OP_SUB, A_X2, A_X2, A_X1);
            4'd5: w = uw(OP_SUB, A_X2, A_X2, ys);
            4'd6: w = uw(OP_MUL, A_X1, ys, ys);
            4'd7: w = uw(OP_MUL, A_X1, A_X1, ys);
            default: w = uw(OP_ADD, A_B, A_X2, A_X1);
        endcase
        return w;
    endfunction

    function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
        ucode_t w;
        if (pc >= 7'd7 && pc <= 7'd15) begin
            w = accel_word(4'(pc - 7'd7), A_Y, A_T);
        end else if (pc >= 7'd26 && pc <= 7'd34) begin
            w = accel_word(4'(pc - 7'd26), A_YK, A_TH);
        end else if (pc >= 7'd45 && pc <= 7'd53) begin
            w = accel_word(4'(pc - 7'd45), A_YK, A_TH);
        end else if (pc >= 7'd61 && pc <= 7'd69) begin
            w = accel_word(4'(pc - 7'd61), A_YK, A_TF);
        end else begin
            case (pc)
                7'd0:  w = uw(OP_MOV, A_T, A_ST, A_ST);
                7'd1:  w = uw(OP_MOV, A_Y, A_SY, A_SY);
                7'd2:  w = uw(OP_MOV, A_V, A_SV, A_SV);
                7'd4:  w = uw(OP_HALF, A_X1, A_H, A_H);
                7'd5:  w = uw(OP_ADD, A_TH, A_T, A_X1);
                7'd6:  w = uw(OP_ADD, A_TF, A_T, A_H);
                7'd16: w = uw(OP_MOV, A_SA, A_V, A_V);
                7'd17: w = uw(OP_MOV, A_SB, A_B, A_B);
                7'd18: w = uw(OP_MUL, A_X1, A_H, A_V);
                7'd19: w = uw(OP_HALF, A_X1, A_X1, A_X1);
                7'd20: w = uw(OP_ADD, A_YK, A_Y, A_X1);
                7'd21: w = uw(OP_MUL, A_X1, A_H, A_B);
                7'd22: w = uw(OP_HALF, A_X1, A_X1, A_X1);
                7'd23: w = uw(OP_ADD, A_AK, A_V, A_X1);
                7'd24: w = uw(OP_ADD, A_X1, A_AK, A_AK);
                7'd25: w = uw(OP_ADD, A_SA, A_SA, A_X1);
                7'd35: w = uw(OP_ADD, A_X1, A_B, A_B);
                7'd36: w = uw(OP_ADD, A_SB, A_SB, A_X1);
                7'd37: w = uw(OP_MUL, A_X1, A_H, A_AK);
                7'd38: w = uw(OP_HALF, A_X1, A_X1, A_X1);
                7'd39: w = uw(OP_ADD, A_YK, A_Y, A_X1);
                7'd40: w = uw(OP_MUL, A_X1, A_H, A_B);
                7'd41: w = uw(OP_HALF, A_X1, A_X1, A_X1);
                7'd42: w = uw(OP_ADD, A_AK, A_V, A_X1);
                7'd43: w = uw(OP_ADD, A_X1, A_AK, A_AK);
                7'd44: w = uw(OP_ADD, A_SA, A_SA, A_X1);
                7'd54: w = uw(OP_ADD, A_X1, A_B, A_B);
                7'd55: w = uw(OP_ADD, A_SB, A_SB, A_X1);
                7'd56: w = uw(OP_MUL, A_X1, A_H, A_AK);
                7'd57: w = uw(OP_ADD, A_YK, A_Y, A_X1);
                7'd58: w = uw(OP_MUL, A_X1, A_H, A_B);
                7'd59: w = uw(OP_ADD, A_AK, A_V, A_X1);
                7'd60: w = uw(OP_ADD, A_SA, A_SA, A_AK);
                7'd70: w = uw(OP_ADD, A_SB, A_SB, A_B);
                7'd71: w = uw(OP_MUL, A_X1, A_H, A_SA);
                7'd72: w = uw(OP_DIV6, A_X1, A_X1, A_X1);
                7'd73: w = uw(OP_ADD, A_Y, A_Y, A_X1);
                7'd74: w = uw(OP_MUL, A_X1, A_H, A_SB);
                7'd75: w = uw(OP_DIV6, A_X1, A_X1, A_X1);
                7'd76: w = uw(OP_ADD, A_V, A_V, A_X1);
                7'd77: w = uw(OP_SAT52, A_T, A_TF, A_TF);
                default: w = uw(OP_END, A_X1, A_X1, A_X1);
            endcase
        end
        return w;
    endfunction

    // Results carry the overflow flag in bit 64.
    function automatic logic [64:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return {1'b1, S64_MAX};
        if (a[63] && b[63] && !s[63]) return {1'b1, S64_MIN};
        return {1'b0, s};
    endfunction

    function automatic logic [64:0] sat_sub(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (!a[63] && b[63] && s[63]) return {1'b1, S64_MAX};
        if (a[63] && !b[63] && !s[63]) return {1'b1, S64_MIN};
        return {1'b0, s};
    endfunction

    function automatic logic [64:0] from_mag(logic hi_nz, logic [63:0] q, logic neg);
        if (neg) begin
            if (hi_nz || q > S64_MIN) return {1'b1, S64_MIN};
            return {1'b0, 64'd0 - q};
        end
        if (hi_nz || q[63]) return {1'b1, S64_MAX};
        return {1'b0, q};
    endfunction

    function automatic logic [63:0] mag(logic [63:0] a);
        return a[63] ? 64'd0 - a : a;
    endfunction

endpackage

FILE: rtl/rk4_nonlinear_radial_ode_step_unit.sv
// ============================================================================
// RK4 nonlinear radial ODE step unit
// Integrates y'' = -y/t + y/t^2 - y + y^3 with classic fourth-order
// Runge-Kutta in signed fixed point, one step or restart per input beat.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_restart
//  m_       out        m_valid / m_ready    m_time_now, m_position,
//                                           m_velocity, m_status
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A step beat runs 75 microcode words, among them eight bit-serial divides and
// twenty-two four-partial multiplies, which all go through one shared unit.
// Reset is synchronous and loads the default start state. The result waits in
// an output register; a stalled result holds the sequencer at its last word.
module rk4_nonlinear_radial_ode_step_unit
    import rk4_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [51:0]   m_time_now,
    output logic signed [63:0]   m_position,
    output logic signed [63:0]   m_velocity,
    output logic [1:0]           m_status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam logic [63:0] ONE_VAL  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] STEP_MAG = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [63:0] STEP_RST = 64'd0 - STEP_MAG;
    localparam logic [63:0] T_RST    = (FRAC_BITS <= 42) ? (64'd400 << FRAC_BITS)
                                                          : T52_MAX64;
    localparam logic [63:0] RECIP3   = 64'hAAAA_AAAA_AAAA_AAAB;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]      state_reg;
    logic [PC_W-1:0] pc_reg;
    logic            ovf_reg, fault_reg;
    ucode_t          uc;

    logic [63:0] step_reg, st_t_reg, st_y_reg, st_v_reg;
    logic [63:0] t_reg, y_reg, v_reg;
    logic [63:0] regf [16];
    logic [63:0] opa_reg, opb_reg;

    logic [63:0]  mua_reg, mub_reg, pp_reg;
    logic [127:0] acc_reg;
    logic         neg_reg;
    logic [5:0]   cnt_reg;
    logic [63:0]  dr_reg, dn_reg, dq_reg, dd_reg;
    logic         dzero_reg, dsat_reg;

    logic         m_valid_reg;
    logic [51:0]  m_time_reg;
    logic [63:0]  m_pos_reg, m_vel_reg;
    logic [1:0]   m_status_reg;

    logic         res_we;
    logic [64:0]  res;
    logic [63:0]  half_sum;
    logic [127:0] acc_shift;
    logic [127:0] pp_ext;
    logic [64:0]  div_r2;
    logic         out_load;
    logic [63:0]  ua_w, ub_w, nhi_w, nlo_w;
    logic         neg_w;

    assign uc        = ucode_rom(pc_reg);
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_EXEC) && (uc.op == OP_END) &&
                       (!m_valid_reg || m_ready);

    assign m_valid    = m_valid_reg;
    assign m_time_now = m_time_reg;
    assign m_position = m_pos_reg;
    assign m_velocity = m_vel_reg;
    assign m_status   = m_status_reg;

    always_comb begin
        half_sum  = opa_reg + {63'd0, opa_reg[63]};
        acc_shift = acc_reg >> FRAC_BITS;
        div_r2    = {dr_reg, dn_reg[63]};
        ua_w      = mag(opa_reg);
        ub_w      = mag(opb_reg);
        nhi_w     = ua_w >> (64 - FRAC_BITS);
        nlo_w     = ua_w << FRAC_BITS;
        neg_w     = opa_reg[63] ^ opb_reg[63];
        case (cnt_reg[1:0])
            2'd1:    pp_ext = {64'd0, pp_reg};
            2'd2:    pp_ext = {32'd0, pp_reg, 32'd0};
            2'd3:    pp_ext = {32'd0, pp_reg, 32'd0};
            default: pp_ext = {pp_reg, 64'd0};
        endcase
        if (cnt_reg == 6'd1) begin
            pp_ext = {64'd0, pp_reg};
        end
    end

    always_comb begin
        res_we = 1'b0;
        res    = {1'b0, opa_reg};
        if (state_reg == S_EXEC) begin
            case (uc.op)
                OP_MOV: begin
                    res_we = 1'b1;
                end
                OP_ADD: begin
                    res_we = 1'b1;
                    res    = sat_add(opa_reg, opb_reg);
                end
                OP_SUB: begin
                    res_we = 1'b1;
                    res    = sat_sub(opa_reg, opb_reg);
                end
                OP_HALF: begin
                    res_we = 1'b1;
                    res    = {1'b0, half_sum[63], half_sum[63:1]};
                end
                OP_SAT52: begin
                    res_we = 1'b1;
                    if (!opa_reg[63] && (opa_reg[62:51] != 12'd0)) begin
                        res = {1'b1, T52_MAX64};
                    end else if (opa_reg[63] && (opa_reg[62:51] != 12'hFFF)) begin
                        res = {1'b1, T52_MIN64};
                    end
                end
                default: begin
                    res_we = 1'b0;
                end
            endcase
        end else if (state_reg == S_FIN) begin
            res_we = 1'b1;
            if (uc.op == OP_MUL) begin
                res = from_mag(|acc_shift[127:64], acc_shift[63:0], neg_reg);
            end else if (uc.op == OP_DIV6) begin
                res = from_mag(1'b0, {1'b0, acc_reg[127:65]}, neg_reg);
            end else if (dzero_reg) begin
                res = {1'b0, 64'd0};
            end else begin
                res = from_mag(dsat_reg, dq_reg, neg_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RST;
            st_t_reg <= T_RST;
            st_y_reg <= ONE_VAL;
            st_v_reg <= 64'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_STEP: step_reg <= {{22{cfg_data[41]}}, cfg_data[41:0]};
                REG_ST_T: st_t_reg <= {{12{cfg_data[51]}}, cfg_data[51:0]};
                REG_ST_Y: st_y_reg <= cfg_data;
                REG_ST_V: st_v_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (res_we && (uc.dst != A_T) && (uc.dst != A_Y) && (uc.dst != A_V)) begin
            regf[uc.dst] <= res[63:0];
        end
        if (state_reg == S_FETCH) begin
            case (uc.sa)
                A_T:     opa_reg <= t_reg;
                A_Y:     opa_reg <= y_reg;
                A_V:     opa_reg <= v_reg;
                A_H:     opa_reg <= step_reg;
                A_ST:    opa_reg <= st_t_reg;
                A_SY:    opa_reg <= st_y_reg;
                A_SV:    opa_reg <= st_v_reg;
                default: opa_reg <= regf[uc.sa];
            endcase
            case (uc.sb)
                A_T:     opb_reg <= t_reg;
                A_Y:     opb_reg <= y_reg;
                A_V:     opb_reg <= v_reg;
                A_H:     opb_reg <= step_reg;
                A_ST:    opb_reg <= st_t_reg;
                A_SY:    opb_reg <= st_y_reg;
                A_SV:    opb_reg <= st_v_reg;
                default: opb_reg <= regf[uc.sb];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC && (uc.op == OP_MUL || uc.op == OP_DIV6)) begin
            if (uc.op == OP_DIV6) begin
                mua_reg <= ua_w >> 1;
                mub_reg <= RECIP3;
                neg_reg <= opa_reg[63];
            end else begin
                mua_reg <= ua_w;
                mub_reg <= ub_w;
                neg_reg <= neg_w;
            end
            acc_reg <= 128'd0;
        end else if (state_reg == S_EXEC && uc.op == OP_DIV) begin
            dd_reg    <= ub_w;
            dr_reg    <= nhi_w;
            dn_reg    <= nlo_w;
            dq_reg    <= 64'd0;
            neg_reg   <= neg_w;
            dzero_reg <= (ub_w == 64'd0);
            dsat_reg  <= (ub_w != 64'd0) && (nhi_w >= ub_w);
        end else if (state_reg == S_MUL) begin
            pp_reg <= (cnt_reg[1] ? {32'd0, mua_reg[63:32]} : {32'd0, mua_reg[31:0]}) *
                      (cnt_reg[0] ? {32'd0, mub_reg[63:32]} : {32'd0, mub_reg[31:0]});
            if (cnt_reg != 6'd0) begin
                acc_reg <= acc_reg + pp_ext;
            end
        end else if (state_reg == S_DIV) begin
            dn_reg <= {dn_reg[62:0], 1'b0};
            if (div_r2 >= {1'b0, dd_reg}) begin
                dr_reg <= 64'(div_r2 - {1'b0, dd_reg});
                dq_reg <= {dq_reg[62:0], 1'b1};
            end else begin
                dr_reg <= div_r2[63:0];
                dq_reg <= {dq_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pc_reg       <= PC_RESTART;
            cnt_reg      <= 6'd0;
            ovf_reg      <= 1'b0;
            fault_reg    <= 1'b0;
            t_reg        <= T_RST;
            y_reg        <= ONE_VAL;
            v_reg        <= 64'd0;
            m_valid_reg  <= 1'b0;
            m_status_reg <= ST_OK;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (res_we) begin
                ovf_reg   <= ovf_reg | res[64];
                pc_reg    <= pc_reg + 7'd1;
                state_reg <= S_FETCH;
                if (uc.dst == A_T) t_reg <= res[63:0];
                if (uc.dst == A_Y) y_reg <= res[63:0];
                if (uc.dst == A_V) v_reg <= res[63:0];
                if (state_reg == S_FIN && uc.op == OP_DIV && dzero_reg) begin
                    fault_reg <= 1'b1;
                end
            end else begin
                unique case (state_reg)
                    S_IDLE: begin
                        if (s_valid) begin
                            pc_reg    <= s_restart ? PC_RESTART : PC_STEP;
                            ovf_reg   <= 1'b0;
                            fault_reg <= 1'b0;
                            state_reg <= S_FETCH;
                        end
                    end
                    S_FETCH: begin
                        state_reg <= S_EXEC;
                    end
                    S_EXEC: begin
                        cnt_reg <= 6'd0;
                        if (uc.op == OP_MUL || uc.op == OP_DIV6) begin
                            state_reg <= S_MUL;
                        end else if (uc.op == OP_DIV) begin
                            state_reg <= ((ub_w == 64'd0) || (nhi_w >= ub_w)) ? S_FIN
                                                                              : S_DIV;
                        end else if (uc.op == OP_JZ) begin
                            state_reg <= S_FETCH;
                            if (opa_reg == 64'd0 || opb_reg == 64'd0) begin
                                fault_reg <= 1'b1;
                                pc_reg    <= uc.tgt;
                            end else begin
                                pc_reg <= pc_reg + 7'd1;
                            end
                        end else if (out_load) begin
                            m_valid_reg  <= 1'b1;
                            m_time_reg   <= t_reg[51:0];
                            m_pos_reg    <= y_reg;
                            m_vel_reg    <= v_reg;
                            m_status_reg <= fault_reg ? ST_FAULT : (ovf_reg ? ST_OVF : ST_OK);
                            state_reg    <= S_IDLE;
                        end
                    end
                    S_MUL: begin
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd4) begin
                            state_reg <= S_FIN;
                        end
                    end
                    S_DIV: begin
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd63) begin
                            state_reg <= S_FIN;
                        end
                    end
                    default: begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_FETCH))
        else $error("accepted beat did not start the sequencer");

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (pc_reg <= PC_LAST))
        else $error("microcode counter ran past the program");

    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (cnt_reg <= 6'd4))
        else $error("multiplier ran more than four partials");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid && s_ready))
        else $error("result load did not present a beat");

endmodule
